/* hw/rtl/hec_pkg.sv */
// Package: constants, types and jet color function for the colormap core.
`timescale 1ns / 1ps
package hec_pkg;
   localparam int HIST_BINS = 4096;
   localparam int BIN_W = $clog2(HIST_BINS);
   localparam int CNT_W = 23;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam int EQ_W = 10;
   localparam int Q_W = 12;
   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_BORDER = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_COL_RD, ST_COL_OUT,
      ST_SW_RD, ST_SW_ADD, ST_SW_DIV, ST_SW_WR, ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } color_type;

   function automatic color_type jet_color(input logic [EQ_W-1:0] x);
      color_type c;
      logic [10:0] xe;
      xe = {1'b0, x};
      c = '0;
      if (xe < 11'd128) begin
         c.b = 8'(11'd128 + xe);
      end else if (xe < 11'd384) begin
         c.b = 8'd255;
         c.g = 8'(xe - 11'd128);
      end else if (xe < 11'd640) begin
         c.b = 8'(11'd639 - xe);
         c.g = 8'd255;
         c.r = 8'(xe - 11'd384);
      end else if (xe < 11'd896) begin
         c.g = 8'(11'd895 - xe);
         c.r = 8'd255;
      end else begin
         c.r = 8'(11'd1151 - xe);
      end
      return c;
   endfunction
endpackage

/* hw/rtl/histogram_equalized_colormap_core.sv */
// Top level: histogram-equalized jet colormap core.
`timescale 1ns / 1ps
// Usage
//   Input items: start/busy command port. An item is taken at a clock edge
//   with start high and busy low; fields on req_* ports.
//   Accumulate items (req_action 0) give no result: the block reads the bin,
//   writes the bin and goes back to idle.
//   Colorize items (req_action 1) give one result on rsp_* for one cycle,
//   flagged by rsp_strobe, registered after ST_COL_RD and ST_COL_OUT; if
//   not the last, the next item can be taken in the cycle the result shows.
//   The last accumulate item runs the table sweep: each bin is read, summed
//   and divided by the pixel count in a 12-step restoring divider.
//   The last colorize item clears the histogram, one bin a cycle.
//   busy is high for all of this.
//   Reset: after reset the block runs the clearing pass before it takes
//   items; csr writes are taken at any time. The table is flagged not ready,
//   so colorize gives level zero until the first sweep.
//   The receiver cannot stall: each result must be taken when shown.
module histogram_equalized_colormap_core
   import hec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_pixel_value,
   input  logic [10:0] req_row_index,
   input  logic [10:0] req_col_index,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_red,
   output logic        rsp_painted,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   state_type state_ff, state_in;
   logic [11:0] rows_ff, cols_ff;
   logic [7:0]  border_ff;
   logic [CNT_W-1:0] count_ff;
   logic ready_ff;
   logic [BIN_W-1:0] addr_ff;
   logic raw_nz_ff, paint_ok_ff, last_ff;
   logic [CNT_W-1:0] cum_ff;
   // divider: remainder and quotient
   logic [CNT_W:0] rem_ff;
   logic [36:0] num_ff;
   logic [Q_W-1:0] quo_ff;
   logic [3:0] step_ff;
   logic rsp_strobe_ff;
   color_type color_ff;
   logic painted_ff;

   logic hist_we, eq_we;
   logic [CNT_W-1:0] hist_wd, hist_rd;
   logic [EQ_W-1:0] eq_rd;

   // saturate value to bin index
   logic [BIN_W-1:0] bin_sel;
   assign bin_sel = (req_pixel_value > 16'(HIST_BINS - 1)) ?
                    BIN_W'(HIST_BINS - 1) : BIN_W'(req_pixel_value);

   // border test in signed 14-bit arithmetic
   logic signed [13:0] rs, cs, bws, rlim, clim;
   logic inside_ok;
   always_comb begin
      rs = 14'(req_row_index);
      cs = 14'(req_col_index);
      bws = 14'(border_ff);
      rlim = 14'(rows_ff) - bws;
      clim = 14'(cols_ff) - bws;
      inside_ok = !(rs < bws || rs > rlim || cs < bws || cs > clim);
   end

   logic take;
   assign take = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   hec_ram #(.WIDTH(CNT_W), .DEPTH(HIST_BINS)) u_hist (
      .clock(clock), .wr_en(hist_we), .addr(addr_ff),
      .wr_data(hist_wd), .rd_data(hist_rd));
   hec_ram #(.WIDTH(EQ_W), .DEPTH(HIST_BINS)) u_eq (
      .clock(clock), .wr_en(eq_we), .addr(addr_ff),
      .wr_data(quo_ff[Q_W-1:2]), .rd_data(eq_rd));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) state_in = req_action ? ST_COL_RD : ST_ACC_RD;
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: state_in = last_ff ? ST_SW_RD : ST_IDLE;
         ST_COL_RD: state_in = ST_COL_OUT;
         ST_COL_OUT: state_in = last_ff ? ST_CLEAR : ST_IDLE;
         ST_SW_RD: state_in = ST_SW_ADD;
         ST_SW_ADD: state_in = ST_SW_DIV;
         ST_SW_DIV: if (step_ff == 4'(Q_W - 1)) state_in = ST_SW_WR;
         ST_SW_WR: state_in = (addr_ff == BIN_W'(HIST_BINS - 1)) ? ST_IDLE : ST_SW_RD;
         ST_CLEAR: if (addr_ff == BIN_W'(HIST_BINS - 1)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      hist_we = 1'b0;
      hist_wd = '0;
      eq_we = 1'b0;
      case (state_ff)
         ST_ACC_WR: begin
            hist_we = raw_nz_ff && (hist_rd != CNT_MAX);
            hist_wd = hist_rd + CNT_W'(1);
         end
         ST_CLEAR: hist_we = 1'b1;
         ST_SW_WR: eq_we = 1'b1;
         default: hist_we = 1'b0;
      endcase
   end

   // one restoring divide step
   logic [CNT_W+1:0] trial;
   assign trial = {rem_ff, num_ff[36]} - {2'b0, count_ff};

   logic [CNT_W:0] cum_sum;
   assign cum_sum = {1'b0, cum_ff} + {1'b0, hist_rd};
   logic [CNT_W-1:0] cum_clip;
   assign cum_clip = (cum_sum > {1'b0, count_ff}) ? count_ff : cum_sum[CNT_W-1:0];

   // cum * 4095 as a shift and subtract; numerator < 2^35
   logic [34:0] prod;
   assign prod = {cum_clip, 12'd0} - 35'(cum_clip);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rows_ff <= 12'd800;
         cols_ff <= 12'd1280;
         border_ff <= 8'd8;
         count_ff <= '0;
         ready_ff <= 1'b0;
         addr_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= (state_ff == ST_COL_OUT);
         if (csr_write) begin
            case (csr_index)
               REG_ROWS: rows_ff <= csr_data;
               REG_COLS: cols_ff <= csr_data;
               REG_BORDER: border_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: if (take) begin
               addr_ff <= bin_sel;
               raw_nz_ff <= (req_pixel_value != 16'd0);
               paint_ok_ff <= (req_pixel_value != 16'd0) && inside_ok;
               last_ff <= req_last;
            end
            ST_ACC_WR: begin
               if (raw_nz_ff && count_ff != CNT_MAX) count_ff <= count_ff + CNT_W'(1);
               if (last_ff) addr_ff <= '0;
               cum_ff <= '0;
            end
            ST_COL_OUT: if (last_ff) begin
               addr_ff <= '0;
               count_ff <= '0;
            end
            ST_SW_ADD: begin
               cum_ff <= cum_clip;
               // upper bits start below the count since cum <= count
               rem_ff <= {1'b0, prod[34:12]};
               num_ff <= {prod[11:0], 25'd0};
               quo_ff <= '0;
               step_ff <= '0;
            end
            ST_SW_DIV: begin
               if (count_ff == '0) begin
                  quo_ff <= '0;
               end else if (!trial[CNT_W+1]) begin
                  rem_ff <= trial[CNT_W:0];
                  quo_ff <= {quo_ff[Q_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[CNT_W-1:0], num_ff[36]};
                  quo_ff <= {quo_ff[Q_W-2:0], 1'b0};
               end
               num_ff <= num_ff << 1;
               step_ff <= step_ff + 4'd1;
            end
            ST_SW_WR: begin
               addr_ff <= addr_ff + BIN_W'(1);
               if (addr_ff == BIN_W'(HIST_BINS - 1)) ready_ff <= 1'b1;
            end
            ST_CLEAR: addr_ff <= addr_ff + BIN_W'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_COL_OUT) begin
         painted_ff <= paint_ok_ff;
         color_ff <= paint_ok_ff ? jet_color(ready_ff ? eq_rd : '0) : '0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_blue = color_ff.b;
   assign rsp_green = color_ff.g;
   assign rsp_red = color_ff.r;
   assign rsp_painted = painted_ff;
endmodule

/* hw/rtl/hec_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module hec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

/* test/tb_top.sv */
// Testbench for the histogram-equalized colormap core: queued items, own predictor, result check.
`timescale 1ns / 1ps
module tb_top;
   import hec_pkg::*;

   typedef struct {
      logic        action;
      logic [15:0] value;
      logic [10:0] row;
      logic [10:0] col;
      logic        last;
   } pixel_item_type;

   typedef struct {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic       painted;
   } color_result_type;

   // idle gaps cover sweeps and the clearing pass
   localparam int STALL_LIMIT = 250000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [15:0] req_pixel_value;
   logic [10:0] req_row_index;
   logic [10:0] req_col_index;
   logic        req_last;
   logic        rsp_strobe;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_red;
   logic        rsp_painted;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [11:0] csr_data;

   histogram_equalized_colormap_core dut (.*);

   // pending stimulus and results still owed by the block
   pixel_item_type   pending_pixels[$];
   color_result_type owed_colors[$];
   int error_count;
   int taken_items;
   int stall_cycles;

   // shadow of the block state
   int          hist_bins[HIST_BINS];
   logic [9:0]  level_table[HIST_BINS];
   int          nonzero_count;
   bit          levels_valid;
   int          cfg_rows;
   int          cfg_cols;
   int          cfg_border;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // cumulative histogram scaled to 0..4095, then quartered to a 10 bit level
   function automatic void build_levels();
      longint running;
      longint scaled;
      running = 0;
      for (int i = 0; i < HIST_BINS; i++) begin
         running += hist_bins[i];
         if (running > nonzero_count) running = nonzero_count;
         scaled = (nonzero_count != 0) ? (running * 4095) / nonzero_count : 0;
         level_table[i] = 10'(scaled >> 2);
      end
      levels_valid = 1'b1;
   endfunction

   function automatic color_result_type jet_of_level(int x);
      color_result_type c;
      c = '{8'd0, 8'd0, 8'd0, 1'b1};
      if (x < 128) begin
         c.b = 8'(128 + x);
      end else if (x < 384) begin
         c.b = 8'd255; c.g = 8'(x - 128);
      end else if (x < 640) begin
         c.b = 8'(639 - x); c.g = 8'd255; c.r = 8'(x - 384);
      end else if (x < 896) begin
         c.g = 8'(895 - x); c.r = 8'd255;
      end else begin
         c.r = 8'(1151 - x);
      end
      return c;
   endfunction

   // update the shadow state for one taken item; queue a color if one is due
   function automatic void predict_pixel(pixel_item_type it);
      int bin;
      int row;
      int col;
      color_result_type c;
      bin = (it.value > 16'd4095) ? 4095 : int'(it.value);
      row = int'(it.row);
      col = int'(it.col);
      if (!it.action) begin
         if (it.value != 0) begin
            if (hist_bins[bin] < int'(CNT_MAX)) hist_bins[bin]++;
            if (nonzero_count < int'(CNT_MAX)) nonzero_count++;
         end
         if (it.last) build_levels();
         return;
      end
      c = '{8'd0, 8'd0, 8'd0, 1'b0};
      // zero pixels and the border band stay unpainted; a band wider than
      // the frame covers everything
      if (it.value != 0 && !(row < cfg_border || row > cfg_rows - cfg_border ||
                             col < cfg_border || col > cfg_cols - cfg_border)) begin
         c = jet_of_level(levels_valid ? int'(level_table[bin]) : 0);
      end
      owed_colors.push_back(c);
      if (it.last) begin
         foreach (hist_bins[i]) hist_bins[i] = 0;
         nonzero_count = 0;
      end
   endfunction

   // driver: holds an item until taken, idles at random between items
   always @(posedge clock) begin
      bit taken;
      bit idle;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            predict_pixel(pending_pixels.pop_front());
            taken_items++;
         end
         if (taken || !start) begin
            // long run with no gaps in the middle of the stream
            idle = (taken_items >= 500 && taken_items < 850) ? 1'b0
                   : ($urandom_range(99) < 22);
            if (pending_pixels.size() > 0 && !idle) begin
               start           <= 1'b1;
               req_action      <= pending_pixels[0].action;
               req_pixel_value <= pending_pixels[0].value;
               req_row_index   <= pending_pixels[0].row;
               req_col_index   <= pending_pixels[0].col;
               req_last        <= pending_pixels[0].last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe must match the oldest owed color
   always @(posedge clock) begin
      color_result_type want;
      if (!reset && rsp_strobe) begin
         if (owed_colors.size() == 0) begin
            $error("unexpected result: blue %0d green %0d red %0d painted %0d",
                   rsp_blue, rsp_green, rsp_red, rsp_painted);
            error_count++;
         end else begin
            want = owed_colors.pop_front();
            if (rsp_blue !== want.b) begin
               $error("blue: expected %0d actual %0d", want.b, rsp_blue);
               error_count++;
            end
            if (rsp_green !== want.g) begin
               $error("green: expected %0d actual %0d", want.g, rsp_green);
               error_count++;
            end
            if (rsp_red !== want.r) begin
               $error("red: expected %0d actual %0d", want.r, rsp_red);
               error_count++;
            end
            if (rsp_painted !== want.painted) begin
               $error("painted: expected %0d actual %0d", want.painted, rsp_painted);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with neither an item taken nor a result shown
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= 12'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      // out-of-range indexes are dropped by the block
      if (idx == REG_ROWS)        cfg_rows   = value & 12'hFFF;
      else if (idx == REG_COLS)   cfg_cols   = value & 12'hFFF;
      else if (idx == REG_BORDER) cfg_border = value & 8'hFF;
   endtask

   task automatic set_frame(int rows, int cols, int border);
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
      write_reg(REG_BORDER, border);
   endtask

   task automatic add_pixel(bit action, int value, int row, int col, bit last);
      pixel_item_type it;
      it.action = action;
      it.value  = 16'(value);
      it.row    = 11'(row);
      it.col    = 11'(col);
      it.last   = last;
      pending_pixels.push_back(it);
   endtask

   // drain everything, then let the sweep or clear finish before touching csrs
   task automatic wait_quiet();
      @(negedge clock);
      while (pending_pixels.size() > 0 || start || owed_colors.size() > 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic int rand_value(int lo, int span);
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return 0;
      if (pick == 1) return $urandom_range(65535);
      return lo + $urandom_range(span);
   endfunction

   function automatic int rand_pos(int extent);
      int top;
      top = (extent < 1) ? 0 : ((extent > 2048) ? 2047 : extent - 1);
      if ($urandom_range(7) == 0) return $urandom_range(2047);
      return $urandom_range(top);
   endfunction

   // one accumulate pass and one colorize pass over random pixels
   task automatic add_frame(int n, int lo, int span);
      for (int i = 0; i < n; i++)
         add_pixel(1'b0, rand_value(lo, span), rand_pos(cfg_rows), rand_pos(cfg_cols),
                   i == n - 1);
      for (int i = 0; i < n; i++)
         add_pixel(1'b1, rand_value(lo, span), rand_pos(cfg_rows), rand_pos(cfg_cols),
                   i == n - 1);
   endtask

   initial begin
      error_count = 0;
      taken_items = 0;
      stall_cycles = 0;
      foreach (hist_bins[i]) hist_bins[i] = 0;
      foreach (level_table[i]) level_table[i] = '0;
      nonzero_count = 0;
      levels_valid = 1'b0;
      cfg_rows = 800;
      cfg_cols = 1280;
      cfg_border = 8;
      reset = 1'b1;
      start = 1'b0;
      req_action = 1'b0;
      req_pixel_value = '0;
      req_row_index = '0;
      req_col_index = '0;
      req_last = 1'b0;
      csr_write = 1'b0;
      csr_index = REG_ROWS;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // colorize before any sweep: level zero, plus a zero pixel and a border pixel
      @(negedge clock);
      add_pixel(1'b1, 500, 100, 100, 1'b0);
      add_pixel(1'b1, 0, 100, 100, 1'b0);
      add_pixel(1'b1, 500, 3, 100, 1'b0);
      add_pixel(1'b1, 65535, 792, 1272, 1'b0);
      add_pixel(1'b1, 1, 793, 100, 1'b1);
      wait_quiet();

      // value extremes and saturation, then colorize them
      add_pixel(1'b0, 0, 0, 0, 1'b0);
      add_pixel(1'b0, 1, 2047, 2047, 1'b0);
      add_pixel(1'b0, 4095, 10, 10, 1'b0);
      add_pixel(1'b0, 4096, 10, 10, 1'b0);
      add_pixel(1'b0, 65535, 10, 10, 1'b0);
      add_pixel(1'b0, 2000, 10, 10, 1'b1);
      add_pixel(1'b1, 1, 8, 8, 1'b0);
      add_pixel(1'b1, 2000, 792, 1272, 1'b0);
      add_pixel(1'b1, 4095, 400, 640, 1'b0);
      add_pixel(1'b1, 65535, 400, 640, 1'b0);
      add_pixel(1'b1, 3000, 2047, 2047, 1'b0);
      add_pixel(1'b1, 1, 7, 7, 1'b1);
      wait_quiet();

      // all-zero accumulate pass gives an all-zero table; accumulate twice in a row
      add_pixel(1'b0, 0, 5, 5, 1'b1);
      add_pixel(1'b0, 7, 5, 5, 1'b1);
      add_pixel(1'b1, 7, 50, 50, 1'b0);
      add_pixel(1'b1, 6, 50, 50, 1'b1);
      wait_quiet();
      write_reg(2'd3, 12'hFFF);

      // random frames over a spread of frame settings
      set_frame(2048, 2048, 0);
      add_frame(120, 1, 4095);
      wait_quiet();
      set_frame(1, 1, 0);
      add_frame(80, 1, 3);
      wait_quiet();
      set_frame(16, 16, 255);
      add_frame(80, 1, 200);
      wait_quiet();
      set_frame(100, 200, 3);
      add_frame(120, 100, 60);
      wait_quiet();
      set_frame(4095, 4095, 1);
      add_frame(120, 0, 65535);
      wait_quiet();
      for (int f = 0; f < 4; f++) begin
         set_frame(1 + $urandom_range(2047), 1 + $urandom_range(2047), $urandom_range(255));
         if (f == 0) cfg_border = cfg_border % 10;
         write_reg(REG_BORDER, cfg_border);
         add_frame(50 + $urandom_range(40), $urandom_range(3000), $urandom_range(1000));
         wait_quiet();
      end
      set_frame(800, 1280, 8);
      add_frame(60, 1, 40);
      wait_quiet();

      repeat (20) @(negedge clock);
      if (error_count == 0 && owed_colors.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
